FILE: hw/rtl/tfoc_pkg.sv
// Shared types, constants and SipHash helpers for the TFO cookie checker.
`timescale 1ns / 1ps
package tfoc_pkg;

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_BYTE  = 1'b1;

	localparam int          CFG_INDEX_W     = 2;
	localparam logic [1:0]  REG_KEY_ENABLED = 2'd0;
	localparam logic [1:0]  REG_KEY_LOW     = 2'd1;
	localparam logic [1:0]  REG_KEY_HIGH    = 2'd2;

	localparam logic [7:0]  KIND_EOL = 8'd0;
	localparam logic [7:0]  KIND_NOP = 8'd1;
	localparam logic [7:0]  KIND_TFO = 8'd34;
	localparam logic [7:0]  TFO_LEN  = 8'd6;
	localparam logic [7:0]  LEN_MIN  = 8'd2;
	localparam int          TFO_COOKIE_BYTES = 4;

	localparam logic [31:0] FIXED_COOKIE = 32'hC07F_0001;
	// "ckie" as the upper four message bytes, little-endian
	localparam logic [31:0] MSG_TAIL     = 32'h6569_6B63;

	localparam logic [63:0] SIP_C0  = 64'h736f_6d65_7073_6575;
	localparam logic [63:0] SIP_C1  = 64'h646f_7261_6e64_6f6d;
	localparam logic [63:0] SIP_C2  = 64'h6c79_6765_6e65_7261;
	localparam logic [63:0] SIP_C3  = 64'h7465_6462_7974_6573;
	localparam logic [63:0] SIP_B   = 64'h0800_0000_0000_0000;
	localparam logic [63:0] SIP_FIN = 64'h0000_0000_0000_00FF;

	// two half rounds per SipRound: 2 compression rounds for each of two message blocks + 4 finalization rounds
	localparam int HASH_STAGES = 16;
	localparam int MSG_STAGE   = 4;
	localparam int FIN_STAGE   = 8;

	localparam int QUEUE_DEPTH = 32;

	typedef logic [3:0][63:0] sip_state_t;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_KIND,
		PH_LEN_OTHER,
		PH_LEN_TFO,
		PH_SKIP,
		PH_COOKIE,
		PH_DRAIN
	} phase_t;

	// one disposition from the parser, in start order
	typedef struct packed {
		logic        drop_prev;
		logic        has_result;
		logic        need_cmp;
		logic [31:0] cookie;
	} rec_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic sip_state_t sip_half(input sip_state_t v, input logic second);
		sip_state_t w;
		w = v;
		if (!second) begin
			w[0] = v[0] + v[1];
			w[1] = rotl(v[1], 13) ^ w[0];
			w[0] = rotl(w[0], 32);
			w[2] = v[2] + v[3];
			w[3] = rotl(v[3], 16) ^ w[2];
		end else begin
			w[0] = v[0] + v[3];
			w[3] = rotl(v[3], 21) ^ w[0];
			w[2] = v[2] + v[1];
			w[1] = rotl(v[1], 17) ^ w[2];
			w[2] = rotl(w[2], 32);
		end
		return w;
	endfunction

endpackage

FILE: hw/rtl/tcp_fast_open_cookie_checker.sv
// Top level: TFO option walker with a pipelined SipHash-2-4 cookie check.
// Throughput: one input transaction per cycle; the input stalls only with 32 cookies in flight.
// Result path: an area that closes before its cookie is hashed reports once the cookie has passed
// the 16-stage half-round hash pipeline, the hash queue and the output register.
// A longer area reports once its closing byte has passed the record queue and the output register.
// Reset (arst_n low) clears parser, queues, credits and key registers at once.
`timescale 1ns / 1ps
module tcp_fast_open_cookie_checker #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [31:0] sequence_number,
	input  logic [5:0]  option_length,
	input  logic [7:0]  option_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        cookie_matches,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [tfoc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [63:0] cfg_data
);

	logic           item_accept;
	logic           start_accept;
	logic           key_enabled_q;
	logic [63:0]    key_low_q, key_high_q;
	logic           hash_valid;
	logic [31:0]    hash_cookie;
	logic           rec_push;
	tfoc_pkg::rec_t rec;

	assign cfg_ready    = 1'b1;
	assign item_accept  = in_valid && !in_stall;
	assign start_accept = item_accept && (command == tfoc_pkg::CMD_START);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_enabled_q <= 1'b0;
			key_low_q     <= '0;
			key_high_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tfoc_pkg::REG_KEY_ENABLED: key_enabled_q <= cfg_data[0];
				tfoc_pkg::REG_KEY_LOW:     key_low_q     <= cfg_data;
				tfoc_pkg::REG_KEY_HIGH:    key_high_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	tfoc_parser #(.MAX_OPTION_BYTES(MAX_OPTION_BYTES)) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_accept  (item_accept),
		.command      (command),
		.option_length(option_length),
		.option_byte  (option_byte),
		.rec_push     (rec_push),
		.rec          (rec)
	);

	tfoc_hash_pipe u_hash (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start_accept),
		.sequence_number(sequence_number),
		.key_enabled    (key_enabled_q),
		.key_low_word   (key_low_q),
		.key_high_word  (key_high_q),
		.cookie_valid   (hash_valid),
		.cookie         (hash_cookie)
	);

	tfoc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_accept  (start_accept),
		.hash_valid    (hash_valid),
		.hash_cookie   (hash_cookie),
		.rec_push      (rec_push),
		.rec           (rec),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.cookie_matches(cookie_matches),
		.in_stall      (in_stall)
	);

endmodule

FILE: hw/rtl/tfoc_parser.sv
// Front end: walks the option area byte by byte and emits one disposition per start.
`timescale 1ns / 1ps
module tfoc_parser #(
	parameter int MAX_OPTION_BYTES = 40
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_accept,
	input  logic            command,
	input  logic [5:0]      option_length,
	input  logic [7:0]      option_byte,
	output logic            rec_push,
	output tfoc_pkg::rec_t  rec
);

	localparam int         REM_W   = $clog2(MAX_OPTION_BYTES + 1);
	localparam logic [5:0] MAX_LEN = 6'(MAX_OPTION_BYTES);

	tfoc_pkg::phase_t phase_q, phase_d;
	logic [REM_W-1:0] rem_q, rem_d;
	logic [REM_W-1:0] skip_q, skip_d;
	logic [31:0]      cap_q, cap_d;
	logic             pend_q, pend_d;

	logic [5:0]       olen_sat;
	logic [REM_W-1:0] olen_rem;
	logic             active;
	logic             len_bad;
	logic [REM_W-1:0] rem_dec;
	logic [REM_W-1:0] skip_dec;
	logic [7:0]       len_body;

	assign olen_sat = (option_length > MAX_LEN) ? MAX_LEN : option_length;
	assign olen_rem = olen_sat[REM_W-1:0];
	assign active   = (phase_q != tfoc_pkg::PH_IDLE) && (rem_q != '0);
	// length must cover kind and length bytes and still fit in the area
	assign len_bad  = (option_byte < tfoc_pkg::LEN_MIN) ||
		({1'b0, option_byte} > (9'(rem_q) + 9'd1));
	assign rem_dec  = rem_q - REM_W'(1);
	assign skip_dec = (skip_q != '0) ? skip_q - REM_W'(1) : skip_q;
	assign len_body = option_byte - tfoc_pkg::LEN_MIN;

	always_comb begin
		phase_d = phase_q;
		if (item_accept) begin
			if (command == tfoc_pkg::CMD_START) begin
				phase_d = (olen_rem == '0) ? tfoc_pkg::PH_IDLE : tfoc_pkg::PH_KIND;
			end else if (!active) begin
				phase_d = tfoc_pkg::PH_IDLE;
			end else begin
				case (phase_q)
					tfoc_pkg::PH_KIND: begin
						if (option_byte == tfoc_pkg::KIND_EOL) begin
							phase_d = tfoc_pkg::PH_DRAIN;
						end else if (option_byte == tfoc_pkg::KIND_NOP) begin
							phase_d = tfoc_pkg::PH_KIND;
						end else if (rem_q == REM_W'(1)) begin
							phase_d = tfoc_pkg::PH_DRAIN;
						end else if (option_byte == tfoc_pkg::KIND_TFO) begin
							phase_d = tfoc_pkg::PH_LEN_TFO;
						end else begin
							phase_d = tfoc_pkg::PH_LEN_OTHER;
						end
					end
					tfoc_pkg::PH_LEN_OTHER, tfoc_pkg::PH_LEN_TFO: begin
						if (len_bad) begin
							phase_d = tfoc_pkg::PH_DRAIN;
						end else if (phase_q == tfoc_pkg::PH_LEN_TFO &&
							option_byte == tfoc_pkg::TFO_LEN) begin
							phase_d = tfoc_pkg::PH_COOKIE;
						end else if (option_byte == tfoc_pkg::LEN_MIN) begin
							phase_d = tfoc_pkg::PH_KIND;
						end else begin
							phase_d = tfoc_pkg::PH_SKIP;
						end
					end
					tfoc_pkg::PH_SKIP: begin
						if (skip_dec == '0) phase_d = tfoc_pkg::PH_KIND;
					end
					tfoc_pkg::PH_COOKIE: begin
						if (skip_dec == '0) phase_d = tfoc_pkg::PH_DRAIN;
					end
					default: phase_d = phase_q;
				endcase
				if (rem_dec == '0) phase_d = tfoc_pkg::PH_IDLE;
			end
		end
	end

	always_comb begin
		rem_d    = rem_q;
		skip_d   = skip_q;
		cap_d    = cap_q;
		pend_d   = pend_q;
		rec_push = 1'b0;
		rec      = '0;
		if (item_accept) begin
			if (command == tfoc_pkg::CMD_START) begin
				rem_d          = olen_rem;
				skip_d         = '0;
				cap_d          = '0;
				pend_d         = 1'b0;
				// an open area is abandoned: its hash gets dropped downstream
				rec.drop_prev  = (phase_q != tfoc_pkg::PH_IDLE);
				rec.has_result = (olen_rem == '0);
				rec_push       = rec.drop_prev || rec.has_result;
			end else if (active) begin
				case (phase_q)
					tfoc_pkg::PH_LEN_OTHER, tfoc_pkg::PH_LEN_TFO: begin
						if (!len_bad) begin
							if (phase_q == tfoc_pkg::PH_LEN_TFO &&
								option_byte == tfoc_pkg::TFO_LEN) begin
								cap_d  = '0;
								skip_d = REM_W'(tfoc_pkg::TFO_COOKIE_BYTES);
							end else if (option_byte != tfoc_pkg::LEN_MIN) begin
								skip_d = len_body[REM_W-1:0];
							end
						end
					end
					tfoc_pkg::PH_SKIP: begin
						skip_d = skip_dec;
					end
					tfoc_pkg::PH_COOKIE: begin
						cap_d  = {cap_q[23:0], option_byte};
						skip_d = skip_dec;
						// compare waits for the hash in the back end
						if (skip_dec == '0) pend_d = 1'b1;
					end
					default: ;
				endcase
				rem_d = rem_dec;
				if (rem_dec == '0) begin
					rec_push       = 1'b1;
					rec.has_result = 1'b1;
					rec.need_cmp   = pend_d;
					rec.cookie     = cap_d;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= tfoc_pkg::PH_IDLE;
			rem_q   <= '0;
			skip_q  <= '0;
			cap_q   <= '0;
			pend_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			rem_q   <= rem_d;
			skip_q  <= skip_d;
			cap_q   <= cap_d;
			pend_q  <= pend_d;
		end
	end

endmodule

FILE: hw/rtl/tfoc_hash_pipe.sv
// SipHash-2-4 cookie pipeline: one half round per stage, a new start every cycle.
`timescale 1ns / 1ps
module tfoc_hash_pipe (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] sequence_number,
	input  logic        key_enabled,
	input  logic [63:0] key_low_word,
	input  logic [63:0] key_high_word,
	output logic        cookie_valid,
	output logic [31:0] cookie
);

	localparam int N = tfoc_pkg::HASH_STAGES;

	logic [63:0]          msg;
	tfoc_pkg::sip_state_t init;

	logic [N-1:0]         vld_s;
	tfoc_pkg::sip_state_t st_s  [N];
	logic [63:0]          msg_s [N];
	logic                 en_s  [N];
	tfoc_pkg::sip_state_t pre   [N];

	// sequence bytes in wire order, read as a little-endian word
	assign msg = {tfoc_pkg::MSG_TAIL, sequence_number[7:0], sequence_number[15:8],
		sequence_number[23:16], sequence_number[31:24]};

	always_comb begin
		init[0] = key_low_word  ^ tfoc_pkg::SIP_C0;
		init[1] = key_high_word ^ tfoc_pkg::SIP_C1;
		init[2] = key_low_word  ^ tfoc_pkg::SIP_C2;
		init[3] = key_high_word ^ tfoc_pkg::SIP_C3 ^ msg;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		localparam logic SECOND = ((i % 2) == 1);
		if (i == 0) begin : g_first
			assign pre[i] = init;
			always_ff @(posedge clk) begin
				st_s[i]  <= tfoc_pkg::sip_half(pre[i], SECOND);
				msg_s[i] <= msg;
				en_s[i]  <= key_enabled;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[i] <= 1'b0;
				else         vld_s[i] <= start;
			end
		end else begin : g_rest
			always_comb begin
				pre[i] = st_s[i-1];
				if (i == tfoc_pkg::MSG_STAGE) begin
					pre[i][0] = st_s[i-1][0] ^ msg_s[i-1];
					pre[i][3] = st_s[i-1][3] ^ tfoc_pkg::SIP_B;
				end
				if (i == tfoc_pkg::FIN_STAGE) begin
					pre[i][0] = st_s[i-1][0] ^ tfoc_pkg::SIP_B;
					pre[i][2] = st_s[i-1][2] ^ tfoc_pkg::SIP_FIN;
				end
			end
			always_ff @(posedge clk) begin
				st_s[i]  <= tfoc_pkg::sip_half(pre[i], SECOND);
				msg_s[i] <= msg_s[i-1];
				en_s[i]  <= en_s[i-1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) vld_s[i] <= 1'b0;
				else         vld_s[i] <= vld_s[i-1];
			end
		end
	end

	logic [63:0] fold;
	assign fold         = st_s[N-1][0] ^ st_s[N-1][1] ^ st_s[N-1][2] ^ st_s[N-1][3];
	assign cookie_valid = vld_s[N-1];
	assign cookie       = en_s[N-1] ? fold[31:0] : tfoc_pkg::FIXED_COOKIE;

endmodule

FILE: hw/rtl/tfoc_fifo.sv
// Small register queue, one push and one pop per cycle.
`timescale 1ns / 1ps
module tfoc_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign empty = (count_q == '0);
	assign rdata = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

FILE: hw/rtl/tfoc_back.sv
// Back end: pairs dispositions with cookies, compares, and holds the output transaction.
`timescale 1ns / 1ps
module tfoc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start_accept,
	input  logic           hash_valid,
	input  logic [31:0]    hash_cookie,
	input  logic           rec_push,
	input  tfoc_pkg::rec_t rec,
	input  logic           out_stall,
	output logic           out_valid,
	output logic           cookie_matches,
	output logic           in_stall
);

	localparam int DEPTH = tfoc_pkg::QUEUE_DEPTH;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int REC_W = $bits(tfoc_pkg::rec_t);

	logic             hq_empty, rq_empty;
	logic [31:0]      hq_rdata;
	logic [REC_W-1:0] rq_rdata;
	tfoc_pkg::rec_t   head;
	logic             hq_pop, rq_pop;
	logic             both, drop_due, do_drop, do_pair, out_free;

	logic             dropped_q;
	logic [CNT_W-1:0] credit_q;
	logic             out_valid_q;
	logic             match_q;

	tfoc_fifo #(.WIDTH(32), .DEPTH(DEPTH)) u_hash_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (hash_valid),
		.wdata (hash_cookie),
		.pop   (hq_pop),
		.empty (hq_empty),
		.rdata (hq_rdata)
	);

	tfoc_fifo #(.WIDTH(REC_W), .DEPTH(DEPTH)) u_rec_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (rec_push),
		.wdata (REC_W'(rec)),
		.pop   (rq_pop),
		.empty (rq_empty),
		.rdata (rq_rdata)
	);

	assign head     = tfoc_pkg::rec_t'(rq_rdata);
	assign both     = !hq_empty && !rq_empty;
	assign out_free = !out_valid_q || !out_stall;
	assign drop_due = head.drop_prev && !dropped_q;
	// drop the abandoned area's cookie first, then pair with this one
	assign do_drop  = both && drop_due;
	assign do_pair  = both && !drop_due && out_free;
	assign hq_pop   = do_drop || do_pair;
	assign rq_pop   = do_pair || (do_drop && !head.has_result);

	// every start holds one credit until its cookie leaves the queue
	assign in_stall = (credit_q == CNT_W'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dropped_q   <= 1'b0;
			credit_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rq_pop)       dropped_q <= 1'b0;
			else if (do_drop) dropped_q <= 1'b1;
			credit_q <= credit_q + CNT_W'(start_accept) - CNT_W'(hq_pop);
			if (do_pair)         out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_pair) match_q <= head.need_cmp && (head.cookie == hq_rdata);
	end

	assign out_valid      = out_valid_q;
	assign cookie_matches = match_q;

endmodule

FILE: hw/rtl/tfoc_checker.sv
// Port-level assertions for the TFO cookie checker and their bind.
`timescale 1ns / 1ps
module tfoc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        command,
	input logic        out_valid,
	input logic        out_stall,
	input logic        cookie_matches
);

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(cookie_matches))
		else $error("result changed while stalled");

	// credits start empty, so input is open right after reset
	a_open_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> !in_stall)
		else $error("input stalled right after reset");

	// only an accepted start can use up the last credit
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(in_valid && !in_stall && command == tfoc_pkg::CMD_START))
		else $error("input stall rose without an accepted start");

endmodule

bind tcp_fast_open_cookie_checker tfoc_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.command       (command),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cookie_matches(cookie_matches)
);
